// File: hw/rtl/ffsa_pkg.sv
// Shared types and codes for the first-fit segment allocator.
// No dependencies; used by ffsa_ctrl and first_fit_segment_allocator.
`default_nettype none
package ffsa_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int ADDR_BITS_DEF    = 16;
  localparam int POOL_RESET       = 65536;

  localparam int SIZE_W   = 17;  // request_size and pool_size
  localparam int OFFSET_W = 16;  // free_offset and segment_offset
  localparam int STATUS_W = 2;
  localparam int HEADROOM = 8;   // extra bits on stored sizes for merged sums

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

  typedef struct packed {
    logic                ok;
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/ffsa_table.sv
// Segment table storage: one write port, one read port, registered read data.
// Standalone; instantiated by first_fit_segment_allocator.
`default_nettype none
module ffsa_table #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 42
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ffsa_ctrl.sv
// Request sequencer: first-fit scan, split/carve, free lookup, merge and
// table shifting over the segment table. Depends on ffsa_pkg.
`default_nettype none
module ffsa_ctrl #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF,
  localparam int IW  = $clog2(MAX_SEGMENTS),
  localparam int CW  = $clog2(MAX_SEGMENTS + 1),
  localparam int FW  = ADDR_BITS + 1,
  localparam int SW  = (FW > ffsa_pkg::SIZE_W) ? FW : ffsa_pkg::SIZE_W,
  localparam int SZW = SW + ffsa_pkg::HEADROOM,
  localparam int EW  = ADDR_BITS + SZW + 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            action,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]     request_size,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]   free_offset,
  input  wire logic                            pool_size_we,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]     pool_size,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output ffsa_pkg::rsp_t                       rsp,
  output logic                                 rd_en,
  output logic [IW-1:0]                        rd_addr,
  input  wire logic [EW-1:0]                   rd_data,
  output logic                                 wr_en,
  output logic [IW-1:0]                        wr_addr,
  output logic [EW-1:0]                        wr_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_OPEN   = 4'd2;
  localparam logic [3:0] S_SPLIT  = 4'd3;
  localparam logic [3:0] S_PREV   = 4'd4;
  localparam logic [3:0] S_NEXT   = 4'd5;
  localparam logic [3:0] S_MERGE  = 4'd6;
  localparam logic [3:0] S_CLOSE  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  localparam logic [FW-1:0] SPAN     = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [FW-1:0] POOL_RST =
    (ADDR_BITS >= 16) ? FW'(ffsa_pkg::POOL_RESET) : SPAN;
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_SEGMENTS);

  logic [3:0]           state, state_next;
  logic                 act, act_next;
  logic [SW-1:0]        req, req_next;
  logic [ADDR_BITS-1:0] want, want_next;
  logic [CW-1:0]        count, count_next;
  logic [FW-1:0]        frontier, frontier_next;
  logic [CW-1:0]        idx, idx_next;
  logic                 pvalid, pvalid_next;
  logic [IW-1:0]        pidx, pidx_next;
  logic [IW-1:0]        hit, hit_next;
  logic [ADDR_BITS-1:0] cur_off, cur_off_next;
  logic [SZW-1:0]       cur_sz, cur_sz_next;
  logic                 prev_free, prev_free_next;
  logic [SZW-1:0]       prev_sz, prev_sz_next;
  logic [IW-1:0]        rk, rk_next;
  logic [IW-1:0]        wk, wk_next;
  logic [CW-1:0]        left, left_next;
  logic                 pend, pend_next;
  logic                 wphase, wphase_next;
  logic [1:0]           shift_r, shift_r_next;
  ffsa_pkg::rsp_t       rsp_q, rsp_next;

  // fields of the entry coming out of the table
  logic [ADDR_BITS-1:0] d_off;
  logic [SZW-1:0]       d_sz;
  logic                 d_used;
  logic [SZW-1:0]       req_z;
  logic                 match;
  logic                 has_next;
  logic                 next_free;
  logic [IW-1:0]        merge_at;
  logic [1:0]           merge_r;
  logic [FW-1:0]        new_front;
  logic [SW-1:0]        pool_ext;

  assign d_off  = rd_data[ADDR_BITS-1:0];
  assign d_sz   = rd_data[ADDR_BITS +: SZW];
  assign d_used = rd_data[EW-1];
  assign req_z  = SZW'(req);
  assign match  = (act == ffsa_pkg::ACT_ALLOC) ? (!d_used && (req_z <= d_sz))
                                               : (d_off == want);
  assign has_next  = (CW'(hit) + CW'(1)) < count;
  assign next_free = has_next && !d_used;
  assign merge_at  = prev_free ? (hit - IW'(1)) : hit;
  assign merge_r   = {1'b0, prev_free} + {1'b0, next_free};
  assign new_front = frontier - FW'(req);
  assign pool_ext  = SW'(pool_size);

  assign in_ready  = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp       = rsp_q;

  always_comb begin
    state_next     = state;
    act_next       = act;
    req_next       = req;
    want_next      = want;
    count_next     = count;
    frontier_next  = frontier;
    idx_next       = idx;
    pvalid_next    = 1'b0;
    pidx_next      = pidx;
    hit_next       = hit;
    cur_off_next   = cur_off;
    cur_sz_next    = cur_sz;
    prev_free_next = prev_free;
    prev_sz_next   = prev_sz;
    rk_next        = rk;
    wk_next        = wk;
    left_next      = left;
    pend_next      = 1'b0;
    wphase_next    = wphase;
    shift_r_next   = shift_r;
    rsp_next       = rsp_q;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next  = action;
          req_next  = SW'(request_size);
          want_next = ADDR_BITS'(free_offset);
          idx_next  = '0;
          if (action == ffsa_pkg::ACT_ALLOC && request_size == '0) begin
            rsp_next   = '{ok: 1'b0, offset: '0, status: ffsa_pkg::ST_NO_SPACE};
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, compare on the returning word
        if (idx < count) begin
          rd_en       = 1'b1;
          rd_addr     = idx[IW-1:0];
          idx_next    = idx + CW'(1);
          pvalid_next = 1'b1;
          pidx_next   = idx[IW-1:0];
        end
        if (pvalid && match) begin
          pvalid_next  = 1'b0;
          hit_next     = pidx;
          cur_off_next = d_off;
          cur_sz_next  = d_sz;
          if (act == ffsa_pkg::ACT_ALLOC) begin
            if (d_sz > req_z) begin
              if (count >= MAX_CNT) begin
                rsp_next   = '{ok: 1'b0, offset: '0,
                               status: ffsa_pkg::ST_TABLE_FULL};
                state_next = S_DONE;
              end else begin
                // open a slot at the hit: move entries hit..count-1 up by one
                rk_next    = IW'(count - CW'(1));
                left_next  = count - CW'(pidx);
                state_next = S_OPEN;
              end
            end else begin
              wr_en      = 1'b1;
              wr_addr    = pidx;
              wr_data    = {1'b1, d_sz, d_off};
              rsp_next   = '{ok: 1'b1, offset: ffsa_pkg::OFFSET_W'(d_off),
                             status: ffsa_pkg::ST_OK};
              state_next = S_DONE;
            end
          end else begin
            state_next = S_PREV;
          end
        end else if (!pvalid && !(idx < count)) begin
          if (act == ffsa_pkg::ACT_FREE) begin
            rsp_next = '{ok: 1'b0, offset: '0, status: ffsa_pkg::ST_NOT_FOUND};
          end else if (SW'(frontier) < req) begin
            rsp_next = '{ok: 1'b0, offset: '0, status: ffsa_pkg::ST_NO_SPACE};
          end else if (count >= MAX_CNT) begin
            rsp_next = '{ok: 1'b0, offset: '0, status: ffsa_pkg::ST_TABLE_FULL};
          end else begin
            // carve downward from the frontier into a new last entry
            frontier_next = new_front;
            wr_en         = 1'b1;
            wr_addr       = count[IW-1:0];
            wr_data       = {1'b1, req_z, ADDR_BITS'(new_front)};
            count_next    = count + CW'(1);
            rsp_next      = '{ok: 1'b1,
                              offset: ffsa_pkg::OFFSET_W'(ADDR_BITS'(new_front)),
                              status: ffsa_pkg::ST_OK};
          end
          state_next = S_DONE;
        end
      end

      S_OPEN: begin
        if (left != '0) begin
          rd_en     = 1'b1;
          rd_addr   = rk;
          rk_next   = rk - IW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
          wk_next   = rk + IW'(1);
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = wk;
          wr_data = rd_data;
        end
        if (left == '0 && !pend) begin
          wphase_next = 1'b0;
          state_next  = S_SPLIT;
        end
      end

      S_SPLIT: begin
        wr_en       = 1'b1;
        wphase_next = 1'b1;
        if (!wphase) begin
          // free remainder sits above, so it takes the lower table slot
          wr_addr = hit;
          wr_data = {1'b0, cur_sz - req_z, cur_off + ADDR_BITS'(req)};
        end else begin
          wr_addr    = hit + IW'(1);
          wr_data    = {1'b1, req_z, cur_off};
          count_next = count + CW'(1);
          rsp_next   = '{ok: 1'b1, offset: ffsa_pkg::OFFSET_W'(cur_off),
                         status: ffsa_pkg::ST_OK};
          state_next = S_DONE;
        end
      end

      S_PREV: begin
        rd_en      = (hit != '0);
        rd_addr    = hit - IW'(1);
        state_next = S_NEXT;
      end

      S_NEXT: begin
        prev_free_next = (hit != '0) && !d_used;
        prev_sz_next   = d_sz;
        rd_en          = has_next;
        rd_addr        = hit + IW'(1);
        state_next     = S_MERGE;
      end

      S_MERGE: begin
        wr_en   = 1'b1;
        wr_addr = merge_at;
        wr_data = {1'b0,
                   cur_sz + (prev_free ? prev_sz : '0) + (next_free ? d_sz : '0),
                   next_free ? d_off : cur_off};
        count_next   = count - CW'(merge_r);
        left_next    = count - CW'(merge_r) - CW'(1) - CW'(merge_at);
        rk_next      = merge_at + IW'(merge_r) + IW'(1);
        shift_r_next = merge_r;
        rsp_next     = '{ok: 1'b1, offset: ffsa_pkg::OFFSET_W'(want),
                         status: ffsa_pkg::ST_OK};
        state_next   = (merge_r == 2'd0) ? S_DONE : S_CLOSE;
      end

      S_CLOSE: begin
        if (left != '0) begin
          rd_en     = 1'b1;
          rd_addr   = rk;
          rk_next   = rk + IW'(1);
          left_next = left - CW'(1);
          pend_next = 1'b1;
          wk_next   = rk - IW'(shift_r);
        end
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = wk;
          wr_data = rd_data;
        end
        if (left == '0 && !pend) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // pool writes must only arrive while idle; the block itself does not enforce it
    if (pool_size_we) begin
      frontier_next = (pool_ext > SW'(SPAN)) ? SPAN : FW'(pool_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      frontier <= POOL_RST;
      pvalid   <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      frontier <= frontier_next;
      pvalid   <= pvalid_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    req       <= req_next;
    want      <= want_next;
    idx       <= idx_next;
    pidx      <= pidx_next;
    hit       <= hit_next;
    cur_off   <= cur_off_next;
    cur_sz    <= cur_sz_next;
    prev_free <= prev_free_next;
    prev_sz   <= prev_sz_next;
    rk        <= rk_next;
    wk        <= wk_next;
    left      <= left_next;
    wphase    <= wphase_next;
    shift_r   <= shift_r_next;
    rsp_q     <= rsp_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT) else $error("segment count beyond table depth");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CW'(wr_addr) <= count) else $error("table write past live entries");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !in_ready) else $error("request taken while result pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |=> in_ready) else $error("no return to idle");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_segment_allocator.sv
// First-fit segment allocator top level: sequencer, segment table, result register.
// Depends on ffsa_pkg, ffsa_table and ffsa_ctrl.
//
// Usage:
//  - Request channel (in_valid/in_ready): action 0 allocates request_size bytes,
//    action 1 frees the segment starting at free_offset. One transaction is
//    worked on at a time; in_ready is high only while the sequencer is idle.
//  - Result channel (out_valid/out_ready): one result per request with ok,
//    segment_offset and status. A result register holds it, so the next
//    request is taken while the previous result still waits.
//  - pool_size_we/pool_size load the pool size (clamped to the address span)
//    and reset the frontier; write only while idle. The table is kept.
//  - Timing: the first-fit scan of N live entries makes one table read per
//    cycle. A split then opens a slot and writes both halves; a free reads
//    the neighbours, merges and closes the gap. The table (one read port,
//    one write port) sets the pace.
//  - Reset: table empty, frontier at the full pool. No clearing pass.
//  - A stalled receiver holds the result register; after one further result
//    is finished the sequencer waits and in_ready stays low.
`default_nettype none
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
  parameter int ADDR_BITS    = ffsa_pkg::ADDR_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           action,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]    request_size,
  input  wire logic [ffsa_pkg::OFFSET_W-1:0]  free_offset,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                ok,
  output logic [ffsa_pkg::OFFSET_W-1:0]       segment_offset,
  output logic [ffsa_pkg::STATUS_W-1:0]       status,
  input  wire logic                           pool_size_we,
  input  wire logic [ffsa_pkg::SIZE_W-1:0]    pool_size
);

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int FW  = ADDR_BITS + 1;
  localparam int SW  = (FW > ffsa_pkg::SIZE_W) ? FW : ffsa_pkg::SIZE_W;
  localparam int SZW = SW + ffsa_pkg::HEADROOM;
  localparam int EW  = ADDR_BITS + SZW + 1;  // {used, size, offset}

  logic           rsp_valid;
  logic           rsp_ready;
  ffsa_pkg::rsp_t rsp;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic [EW-1:0]  rd_data;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [EW-1:0]  wr_data;

  ffsa_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .request_size (request_size),
    .free_offset  (free_offset),
    .pool_size_we (pool_size_we),
    .pool_size    (pool_size),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  ffsa_table #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (EW)
  ) u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // result register: free, or emptied this cycle
  assign rsp_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_valid && rsp_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      ok             <= rsp.ok;
      segment_offset <= rsp.offset;
      status         <= rsp.status;
    end
  end

endmodule
`default_nettype wire

// File: test/tb_first_fit_segment_allocator.sv
// Self-checking testbench for first_fit_segment_allocator.
// Depends on ffsa_pkg and the allocator RTL. Holds its own segment table model
// and compares every result transaction against it.
`timescale 1ns / 1ps
module tb_first_fit_segment_allocator;

  localparam int SEGS      = 32;
  localparam int SPAN      = 65536;
  localparam int DRAIN_CYC = 2 * SEGS + 16;  // worst-case request latency with margin

  typedef struct {
    logic                          act;
    logic [ffsa_pkg::SIZE_W-1:0]   req;
    logic [ffsa_pkg::OFFSET_W-1:0] off;
  } request_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          action = ffsa_pkg::ACT_ALLOC;
  logic [ffsa_pkg::SIZE_W-1:0]   request_size = '0;
  logic [ffsa_pkg::OFFSET_W-1:0] free_offset = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          ok;
  logic [ffsa_pkg::OFFSET_W-1:0] segment_offset;
  logic [ffsa_pkg::STATUS_W-1:0] status;
  logic                          pool_size_we = 1'b0;
  logic [ffsa_pkg::SIZE_W-1:0]   pool_size = '0;

  first_fit_segment_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .request_size(request_size), .free_offset(free_offset),
    .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .segment_offset(segment_offset), .status(status),
    .pool_size_we(pool_size_we), .pool_size(pool_size)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Model of the segment table, kept in descending address order.
  logic [ffsa_pkg::OFFSET_W-1:0] seg_base [SEGS];
  int unsigned                   seg_len  [SEGS];
  bit                            seg_busy [SEGS];
  int unsigned                   seg_count;
  int unsigned                   frontier_left;

  request_t       pending_requests[$];
  ffsa_pkg::rsp_t expected_results[$];
  int             send_idle = 0;
  int             recv_idle = 0;
  int             errors = 0;
  bit             in_taken = 1'b0;

  function automatic int unsigned clamp_span(int unsigned v);
    return (v > SPAN) ? SPAN : v;
  endfunction

  function automatic void open_entry(int unsigned at);
    for (int unsigned k = seg_count; k > at; k--) begin
      seg_base[k] = seg_base[k-1];
      seg_len[k]  = seg_len[k-1];
      seg_busy[k] = seg_busy[k-1];
    end
    seg_count++;
  endfunction

  function automatic void close_entry(int unsigned at);
    for (int unsigned k = at; k + 1 < seg_count; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k]  = seg_len[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    seg_count--;
  endfunction

  // Applies one request to the model and returns the outcome it should give.
  function automatic ffsa_pkg::rsp_t allocate_or_free(request_t r);
    ffsa_pkg::rsp_t res;
    int unsigned    i;
    int unsigned    want;
    int unsigned    base;
    int unsigned    len;
    res = '{ok: 1'b0, offset: '0, status: ffsa_pkg::ST_OK};
    if (r.act == ffsa_pkg::ACT_ALLOC) begin
      want = 32'(r.req);
      if (want == 0) begin
        res.status = ffsa_pkg::ST_NO_SPACE;
        return res;
      end
      for (i = 0; i < seg_count; i++)
        if (!seg_busy[i] && want <= seg_len[i]) break;
      if (i < seg_count) begin
        base = 32'(seg_base[i]);
        len  = seg_len[i];
        if (len > want) begin
          if (seg_count >= SEGS) begin
            res.status = ffsa_pkg::ST_TABLE_FULL;
            return res;
          end
          // free remainder sits above the used part, so it takes slot i
          open_entry(i);
          seg_base[i] = ffsa_pkg::OFFSET_W'(base + want);
          seg_len[i]  = len - want;
          seg_busy[i] = 1'b0;
          i++;
          seg_len[i]  = want;
        end
        seg_busy[i] = 1'b1;
        res.ok     = 1'b1;
        res.offset = ffsa_pkg::OFFSET_W'(base);
        return res;
      end
      if (want > frontier_left) begin
        res.status = ffsa_pkg::ST_NO_SPACE;
        return res;
      end
      if (seg_count >= SEGS) begin
        res.status = ffsa_pkg::ST_TABLE_FULL;
        return res;
      end
      frontier_left -= want;
      seg_base[seg_count] = ffsa_pkg::OFFSET_W'(frontier_left);
      seg_len[seg_count]  = want;
      seg_busy[seg_count] = 1'b1;
      seg_count++;
      res.ok     = 1'b1;
      res.offset = ffsa_pkg::OFFSET_W'(frontier_left);
      return res;
    end
    for (i = 0; i < seg_count; i++)
      if (seg_base[i] == r.off) break;
    if (i >= seg_count) begin
      res.status = ffsa_pkg::ST_NOT_FOUND;
      return res;
    end
    seg_busy[i] = 1'b0;
    if (i > 0 && !seg_busy[i-1]) begin
      // neighbour above: keep own base
      seg_len[i] += seg_len[i-1];
      close_entry(i - 1);
      i--;
    end
    if (i + 1 < seg_count && !seg_busy[i+1]) begin
      // neighbour below: take its base
      seg_base[i] = seg_base[i+1];
      seg_len[i] += seg_len[i+1];
      close_entry(i + 1);
    end
    res.ok     = 1'b1;
    res.offset = r.off;
    return res;
  endfunction

  // Requests are predicted as they are queued; the block takes them in order.
  task automatic queue_request(logic act, int unsigned req, int unsigned off);
    request_t r;
    r.act = act;
    r.req = ffsa_pkg::SIZE_W'(req);
    r.off = ffsa_pkg::OFFSET_W'(off);
    expected_results.push_back(allocate_or_free(r));
    pending_requests.push_back(r);
  endtask

  task automatic queue_random;
    int unsigned sz;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      case ($urandom_range(19))
        0:       sz = $urandom_range(131071);          // any 17-bit value
        1:       sz = $urandom_range(65536, 4096);
        2:       sz = 0;
        default: sz = $urandom_range(96, 1);
      endcase
      queue_request(ffsa_pkg::ACT_ALLOC, sz, $urandom_range(65535));
    end else if (seg_count > 0 && pick < 93) begin
      queue_request(ffsa_pkg::ACT_FREE, $urandom_range(131071),
                    32'(seg_base[$urandom_range(seg_count - 1)]));
    end else begin
      queue_request(ffsa_pkg::ACT_FREE, $urandom_range(131071), $urandom_range(65535));
    end
  endtask

  task automatic drain;
    wait (pending_requests.size() == 0 && expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_pool(int unsigned v);
    drain();
    @(negedge clk);
    pool_size_we <= 1'b1;
    pool_size    <= ffsa_pkg::SIZE_W'(v);
    @(negedge clk);
    pool_size_we <= 1'b0;
    frontier_left = clamp_span(v);
  endtask

  task automatic random_phase(int n, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int k = 0; k < n; k++) begin
      queue_random();
      if (k == n / 2) drain();  // let the block run dry mid-phase
      wait (pending_requests.size() < 4);
    end
  endtask

  // Request driver: holds a transaction until taken, otherwise may idle.
  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
      r = pending_requests.pop_front();
      in_valid     <= 1'b1;
      action       <= r.act;
      request_size <= r.req;
      free_offset  <= r.off;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // Result monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    ffsa_pkg::rsp_t e;
    in_taken <= in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0d offset=%0h status=%0d",
                 $time, ok, segment_offset, status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (ok !== e.ok) begin
          $display("%0t: ok expected %0d actual %0d", $time, e.ok, ok);
          errors++;
        end
        if (segment_offset !== e.offset) begin
          $display("%0t: segment_offset expected %0h actual %0h",
                   $time, e.offset, segment_offset);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    seg_count     = 0;
    frontier_left = SPAN;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero size, carve, split, merge with the neighbour above, refree, not found.
    write_pool(1);
    queue_request(ffsa_pkg::ACT_ALLOC, 1, 0);
    queue_request(ffsa_pkg::ACT_ALLOC, 1, 0);          // frontier exhausted
    queue_request(ffsa_pkg::ACT_FREE, 0, 0);
    queue_request(ffsa_pkg::ACT_FREE, 0, 0);           // already free
    write_pool(131071);                                // saturates to the span
    queue_request(ffsa_pkg::ACT_ALLOC, 0, 0);
    queue_request(ffsa_pkg::ACT_ALLOC, 65536, 0);      // 1-byte hole too small, carves
    queue_request(ffsa_pkg::ACT_ALLOC, 131071, 0);
    write_pool(65536);
    queue_request(ffsa_pkg::ACT_ALLOC, 100, 0);
    queue_request(ffsa_pkg::ACT_ALLOC, 200, 0);
    queue_request(ffsa_pkg::ACT_ALLOC, 300, 0);
    queue_request(ffsa_pkg::ACT_FREE, 0, 65436);
    queue_request(ffsa_pkg::ACT_FREE, 0, 65036);       // no segment starts here: not found
    queue_request(ffsa_pkg::ACT_FREE, 0, 65236);       // merges with the free neighbour above
    queue_request(ffsa_pkg::ACT_ALLOC, 50, 0);         // split of the merged hole
    queue_request(ffsa_pkg::ACT_ALLOC, 1, 0);
    queue_request(ffsa_pkg::ACT_FREE, 0, 16'hFFFF);
    queue_request(ffsa_pkg::ACT_FREE, 0, 16'h1234);
    for (int k = 0; k < 34; k++) queue_request(ffsa_pkg::ACT_ALLOC, 2, 0);  // fill the table
    queue_request(ffsa_pkg::ACT_ALLOC, 1, 0);          // split needed, table full
    queue_request(ffsa_pkg::ACT_ALLOC, 60000, 0);      // no hole fits and the carve is refused: table full

    random_phase(550, 26, 76);
    write_pool(300);
    random_phase(500, 76, 26);
    write_pool(100000);
    random_phase(500, 0, 0);

    wait (pending_requests.size() == 0 && expected_results.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
